### rtl/rpis_pkg.sv
// Shared types and constants for the radial pinch and invert shader.
// Item structs, fixed-point widths, cell state types and register indexes.
// No dependencies.
`default_nettype none

package rpis_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int INT_BITS    = 12;
    localparam int POS_W       = INT_BITS + FRAC_BITS;
    localparam int RAD_W       = POS_W - 1;
    localparam int D_W         = POS_W + 1;
    localparam int SQ_W        = 2 * D_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int S_W         = 2 * RAD_W;
    localparam int IX_W        = D_W - FRAC_BITS;
    localparam int FI_W        = 2 * IX_W + 1;
    localparam int DIST_W      = RAD_W + 1;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int DSH_W       = RAD_W + FRAC_BITS + 1;
    localparam int REM_W       = DSH_W + 2;
    localparam int MUL_W       = D_W + Q_W;
    localparam int SQRT_STAGES = RAD_W;
    localparam int DIV_STAGES  = Q_W;
    localparam int CFG_W       = POS_W;
    localparam int CFG_IDX_W   = 2;
    localparam int COL_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    localparam logic [Q_W-1:0]   ONE_Q     = Q_W'(1) << FRAC_BITS;
    localparam logic [MUL_W-1:0] HALF_Q    = (FRAC_BITS > 0) ?
                                             (MUL_W'(1) << (FRAC_BITS - 1)) : '0;
    localparam logic [S_W-1:0]   SQRT_MSK0 = S_W'(1) << (S_W - 2);
    localparam logic [COL_W-1:0] COL_MAX   = 8'd255;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [COL_W-1:0] red_in;
        logic [COL_W-1:0] green_in;
        logic [COL_W-1:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic [COL_W-1:0] red_out;
        logic [COL_W-1:0] green_out;
        logic [COL_W-1:0] blue_out;
        logic             inside_res;
    } out_item_t;

    typedef struct packed {
        logic [S_W-1:0] x;
        logic [S_W-1:0] r;
        logic [S_W-1:0] msk;
    } sq_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } dv_t;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             hit;
        logic             dx_neg;
        logic             dy_neg;
        logic [D_W-1:0]   ax;
        logic [D_W-1:0]   ay;
    } side_t;

endpackage

`default_nettype wire

### rtl/rpis_sqrt_cell.sv
// One step of the digit-by-digit square root: one root bit per cell.
// Uses rpis_pkg::sq_t.
`default_nettype none

module rpis_sqrt_cell
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire rpis_pkg::sq_t  cur,
    output rpis_pkg::sq_t       nxt
);

    logic [rpis_pkg::S_W:0]   trial;
    logic                     ge;
    rpis_pkg::sq_t            nxt_next;

    always_comb
    begin
        trial = {1'b0, cur.r} + {1'b0, cur.msk};
        ge    = {1'b0, cur.x} >= trial;
        nxt_next.x   = ge ? (cur.x - trial[rpis_pkg::S_W-1:0]) : cur.x;
        nxt_next.r   = ge ? ((cur.r >> 1) + cur.msk) : (cur.r >> 1);
        nxt_next.msk = cur.msk >> 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt <= nxt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rpis_div_cell.sv
// One step of restoring division: one quotient bit per cell.
// Uses rpis_pkg::dv_t and the pre-shifted divisor.
`default_nettype none

module rpis_div_cell
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [rpis_pkg::DSH_W-1:0]   dsh,
    input  wire rpis_pkg::dv_t                cur,
    output rpis_pkg::dv_t                     nxt
);

    logic                         ge;
    logic [rpis_pkg::REM_W-1:0]   rem1;
    rpis_pkg::dv_t                nxt_next;

    always_comb
    begin
        ge   = cur.rem >= {2'b00, dsh};
        rem1 = ge ? (cur.rem - {2'b00, dsh}) : cur.rem;
        nxt_next.rem = rem1 << 1;
        nxt_next.q   = {cur.q[rpis_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt <= nxt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/radial_pinch_and_invert_shader.sv
// Radial pinch and invert shader: top level, front end, cell chains and output stage.
// Depends on rpis_pkg, rpis_sqrt_cell and rpis_div_cell.
//
// Takes one item per cycle while item_stall is low and returns one result per item,
// in order. The pipeline is made of the square-root chain (one root bit per cell,
// 19 cells) and the division chain (one quotient bit per cell, 9 cells), plus
// front-end, rounding, scaling and final-result stages.
// A result register and a one-item skid register sit at the output; item_stall
// is high only while the skid register holds an item.
`default_nettype none

module radial_pinch_and_invert_shader
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rpis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rpis_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire rpis_pkg::in_item_t               item,
    output logic                                  res_valid,
    input  wire logic                             res_stall,
    output rpis_pkg::out_item_t                   res
);

    localparam int ST_SQ0  = 3;
    localparam int ST_RND  = ST_SQ0 + rpis_pkg::SQRT_STAGES;
    localparam int ST_DV0  = ST_RND + 1;
    localparam int ST_M1   = ST_DV0 + rpis_pkg::DIV_STAGES;
    localparam int NST     = ST_M1 + 2;

    logic [rpis_pkg::POS_W-1:0]   cx_reg;
    logic [rpis_pkg::POS_W-1:0]   cy_reg;
    logic [rpis_pkg::RAD_W-1:0]   rad_reg;
    logic [rpis_pkg::S_W-1:0]     rad2_reg;

    logic                         en;
    logic [NST-1:0]               v_reg;
    rpis_pkg::side_t              side_reg [NST];

    logic [rpis_pkg::D_W-1:0]     dx;
    logic [rpis_pkg::D_W-1:0]     dy;
    rpis_pkg::side_t              side0;
    rpis_pkg::side_t              side2;

    logic [rpis_pkg::SQ_W-1:0]    sqx_reg;
    logic [rpis_pkg::SQ_W-1:0]    sqy_reg;
    logic [rpis_pkg::FI_W-1:0]    fi_reg;
    logic [rpis_pkg::IX_W-1:0]    ix;
    logic [rpis_pkg::IX_W-1:0]    iy;

    logic [rpis_pkg::SUM_W-1:0]   s_sum;
    logic [rpis_pkg::SUM_W-1:0]   fi_sh;
    rpis_pkg::sq_t                sq_in_reg;
    rpis_pkg::sq_t                sq_next;
    rpis_pkg::sq_t                sq_chain [rpis_pkg::SQRT_STAGES+1];

    logic [rpis_pkg::DIST_W-1:0]  dist_reg;
    rpis_pkg::dv_t                dv_chain [rpis_pkg::DIV_STAGES+1];
    logic [rpis_pkg::DSH_W-1:0]   dsh;

    logic [rpis_pkg::Q_W-1:0]     q_last;
    logic [rpis_pkg::Q_W-1:0]     q_clip;
    logic [rpis_pkg::Q_W-1:0]     fac;
    logic [rpis_pkg::MUL_W-1:0]   mx_reg;
    logic [rpis_pkg::MUL_W-1:0]   my_reg;

    logic [rpis_pkg::MUL_W-1:0]   mx_rnd;
    logic [rpis_pkg::MUL_W-1:0]   my_rnd;
    logic [rpis_pkg::D_W-1:0]     px_ext;
    logic [rpis_pkg::D_W-1:0]     py_ext;
    logic [rpis_pkg::D_W-1:0]     ox;
    logic [rpis_pkg::D_W-1:0]     oy;
    rpis_pkg::out_item_t          fin_reg;
    rpis_pkg::out_item_t          fin_next;

    logic                         res_valid_reg;
    rpis_pkg::out_item_t          res_reg;
    logic                         skid_v_reg;
    rpis_pkg::out_item_t          skid_reg;
    logic                         out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            rad_reg  <= '0;
            rad2_reg <= '0;
        end
        else
        begin
            rad2_reg <= rpis_pkg::S_W'(rad_reg) * rpis_pkg::S_W'(rad_reg);
            if (cfg_we)
            begin
                case (cfg_index)
                    rpis_pkg::CFG_CENTER_X: cx_reg  <= cfg_data;
                    rpis_pkg::CFG_CENTER_Y: cy_reg  <= cfg_data;
                    rpis_pkg::CFG_RADIUS:   rad_reg <= cfg_data[rpis_pkg::RAD_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    assign en         = !skid_v_reg;
    assign item_stall = skid_v_reg;

    // Front end: offsets and magnitudes
    always_comb
    begin
        dx = {item.pos_x[rpis_pkg::POS_W-1], item.pos_x}
           - {cx_reg[rpis_pkg::POS_W-1], cx_reg};
        dy = {item.pos_y[rpis_pkg::POS_W-1], item.pos_y}
           - {cy_reg[rpis_pkg::POS_W-1], cy_reg};
        side0.func   = item.func;
        side0.pos_x  = item.pos_x;
        side0.pos_y  = item.pos_y;
        side0.red    = item.red_in;
        side0.green  = item.green_in;
        side0.blue   = item.blue_in;
        side0.hit    = 1'b0;
        side0.dx_neg = dx[rpis_pkg::D_W-1];
        side0.dy_neg = dy[rpis_pkg::D_W-1];
        side0.ax     = dx[rpis_pkg::D_W-1] ? (~dx + 1'b1) : dx;
        side0.ay     = dy[rpis_pkg::D_W-1] ? (~dy + 1'b1) : dy;
    end

    assign ix = side_reg[0].ax[rpis_pkg::D_W-1:rpis_pkg::FRAC_BITS];
    assign iy = side_reg[0].ay[rpis_pkg::D_W-1:rpis_pkg::FRAC_BITS];

    // Inside test and radicand
    always_comb
    begin
        s_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        fi_sh = rpis_pkg::SUM_W'({fi_reg, {(2*rpis_pkg::FRAC_BITS){1'b0}}});
        side2 = side_reg[1];
        side2.hit = side_reg[1].func
                  ? (fi_sh < rpis_pkg::SUM_W'(rad2_reg))
                  : (s_sum < rpis_pkg::SUM_W'(rad2_reg));
        sq_next.x   = s_sum[rpis_pkg::S_W-1:0];
        sq_next.r   = '0;
        sq_next.msk = rpis_pkg::SQRT_MSK0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side2;
            for (int i = 3; i < NST; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            sqx_reg   <= rpis_pkg::SQ_W'(side_reg[0].ax) * rpis_pkg::SQ_W'(side_reg[0].ax);
            sqy_reg   <= rpis_pkg::SQ_W'(side_reg[0].ay) * rpis_pkg::SQ_W'(side_reg[0].ay);
            fi_reg    <= rpis_pkg::FI_W'(ix) * rpis_pkg::FI_W'(ix)
                       + rpis_pkg::FI_W'(iy) * rpis_pkg::FI_W'(iy);
            sq_in_reg <= sq_next;
        end
    end

    // Square-root chain
    assign sq_chain[0] = sq_in_reg;

    for (genvar g = 0; g < rpis_pkg::SQRT_STAGES; g++)
    begin : g_sqrt
        rpis_sqrt_cell u_cell
        (
            .clk (clk),
            .en  (en),
            .cur (sq_chain[g]),
            .nxt (sq_chain[g+1])
        );
    end

    // Round the root to nearest
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= rpis_pkg::DIST_W'(sq_chain[rpis_pkg::SQRT_STAGES].r)
                      + rpis_pkg::DIST_W'(sq_chain[rpis_pkg::SQRT_STAGES].x
                                          > sq_chain[rpis_pkg::SQRT_STAGES].r);
        end
    end

    // Division chain: (dist * 2^(F+1) + R) / (2R)
    assign dsh = {rad_reg, {(rpis_pkg::FRAC_BITS+1){1'b0}}};
    assign dv_chain[0].rem = (rpis_pkg::REM_W'(dist_reg) << (rpis_pkg::FRAC_BITS + 1))
                           + rpis_pkg::REM_W'(rad_reg);
    assign dv_chain[0].q   = '0;

    for (genvar g = 0; g < rpis_pkg::DIV_STAGES; g++)
    begin : g_div
        rpis_div_cell u_cell
        (
            .clk (clk),
            .en  (en),
            .dsh (dsh),
            .cur (dv_chain[g]),
            .nxt (dv_chain[g+1])
        );
    end

    // Scale displacements by 1 - q
    assign q_last = dv_chain[rpis_pkg::DIV_STAGES].q;
    assign q_clip = (q_last > rpis_pkg::ONE_Q) ? rpis_pkg::ONE_Q : q_last;
    assign fac    = rpis_pkg::ONE_Q - q_clip;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= rpis_pkg::MUL_W'(side_reg[ST_M1-1].ax) * rpis_pkg::MUL_W'(fac);
            my_reg <= rpis_pkg::MUL_W'(side_reg[ST_M1-1].ay) * rpis_pkg::MUL_W'(fac);
        end
    end

    // Final result
    always_comb
    begin
        mx_rnd = (mx_reg + rpis_pkg::HALF_Q) >> rpis_pkg::FRAC_BITS;
        my_rnd = (my_reg + rpis_pkg::HALF_Q) >> rpis_pkg::FRAC_BITS;
        px_ext = {side_reg[ST_M1].pos_x[rpis_pkg::POS_W-1], side_reg[ST_M1].pos_x};
        py_ext = {side_reg[ST_M1].pos_y[rpis_pkg::POS_W-1], side_reg[ST_M1].pos_y};
        ox = side_reg[ST_M1].dx_neg ? (px_ext + mx_rnd[rpis_pkg::D_W-1:0])
                                    : (px_ext - mx_rnd[rpis_pkg::D_W-1:0]);
        oy = side_reg[ST_M1].dy_neg ? (py_ext + my_rnd[rpis_pkg::D_W-1:0])
                                    : (py_ext - my_rnd[rpis_pkg::D_W-1:0]);
        fin_next.inside_res = side_reg[ST_M1].hit;
        fin_next.out_x      = side_reg[ST_M1].pos_x;
        fin_next.out_y      = side_reg[ST_M1].pos_y;
        fin_next.red_out    = side_reg[ST_M1].red;
        fin_next.green_out  = side_reg[ST_M1].green;
        fin_next.blue_out   = side_reg[ST_M1].blue;
        if (side_reg[ST_M1].hit)
        begin
            if (side_reg[ST_M1].func)
            begin
                fin_next.red_out   = rpis_pkg::COL_MAX - side_reg[ST_M1].red;
                fin_next.green_out = rpis_pkg::COL_MAX - side_reg[ST_M1].green;
                fin_next.blue_out  = rpis_pkg::COL_MAX - side_reg[ST_M1].blue;
            end
            else
            begin
                fin_next.out_x = ox[rpis_pkg::POS_W-1:0];
                fin_next.out_y = oy[rpis_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= fin_next;
        end
    end

    // Output register and skid
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                res_valid_reg <= 1'b1;
                skid_v_reg    <= 1'b0;
            end
        end
        else if (v_reg[NST-1])
        begin
            if (out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_free)
            begin
                res_reg <= skid_reg;
            end
        end
        else if (v_reg[NST-1])
        begin
            if (out_free)
            begin
                res_reg <= fin_reg;
            end
            else
            begin
                skid_reg <= fin_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> res_valid_reg)
        else $error("skid holds an item while the result register is empty");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(v_reg))
        else $error("pipeline advanced while the skid register was full");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_M1-1] && side_reg[ST_M1-1].hit && !side_reg[ST_M1-1].func)
        |-> (q_last <= rpis_pkg::ONE_Q))
        else $error("pinch ratio exceeds one");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && rad2_reg == '0) |-> !side_reg[2].hit)
        else $error("item inside a zero radius");
`endif

endmodule

`default_nettype wire

### dv/tb_radial_pinch_and_invert_shader.sv
// Testbench for the radial pinch and invert shader: drives vertex and fragment items,
// predicts each result in-line and checks it field by field in order.
// Depends on rpis_pkg and radial_pinch_and_invert_shader.
`timescale 1ns / 1ps

module tb_radial_pinch_and_invert_shader;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rpis_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rpis_pkg::CFG_W-1:0]     cfg_data;
    logic                           item_valid;
    logic                           item_stall;
    rpis_pkg::in_item_t             item;
    logic                           res_valid;
    logic                           res_stall;
    rpis_pkg::out_item_t            res;

    radial_pinch_and_invert_shader DUT (.*);

    rpis_pkg::in_item_t  pending_items[$];
    rpis_pkg::out_item_t expected_pixels[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_send = 0;

    logic signed [63:0] cen_x, cen_y;
    logic        [63:0] rad_q;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [63:0] sext(input logic [rpis_pkg::POS_W-1:0] v);
        return {{(64-rpis_pkg::POS_W){v[rpis_pkg::POS_W-1]}}, v};
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] round_root(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        if (s - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic logic signed [63:0] pull(input logic signed [63:0] d,
                                                input logic [63:0] f);
        logic [63:0] m;
        m = (mag(d) * f + (64'd1 << (rpis_pkg::FRAC_BITS - 1))) >> rpis_pkg::FRAC_BITS;
        return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic rpis_pkg::out_item_t shade(input rpis_pkg::in_item_t it);
        rpis_pkg::out_item_t o;
        logic signed [63:0] px, py, dx, dy;
        logic [63:0] ax, ay, s, root, q;
        px = sext(it.pos_x);
        py = sext(it.pos_y);
        dx = px - cen_x;
        dy = py - cen_y;
        ax = mag(dx);
        ay = mag(dy);
        o.out_x = it.pos_x;
        o.out_y = it.pos_y;
        o.red_out = it.red_in;
        o.green_out = it.green_in;
        o.blue_out = it.blue_in;
        o.inside_res = 1'b0;
        if (it.func)
        begin
            s = ((ax >> rpis_pkg::FRAC_BITS) * (ax >> rpis_pkg::FRAC_BITS)
                 + (ay >> rpis_pkg::FRAC_BITS) * (ay >> rpis_pkg::FRAC_BITS))
                << (2 * rpis_pkg::FRAC_BITS);
            if (s < rad_q * rad_q)
            begin
                o.inside_res = 1'b1;
                o.red_out = rpis_pkg::COL_MAX - it.red_in;
                o.green_out = rpis_pkg::COL_MAX - it.green_in;
                o.blue_out = rpis_pkg::COL_MAX - it.blue_in;
            end
        end
        else
        begin
            s = ax * ax + ay * ay;
            if (s < rad_q * rad_q)
            begin
                root = round_root(s);
                q = ((root << (rpis_pkg::FRAC_BITS + 1)) + rad_q) / (rad_q << 1);
                if (q > 64'd256)
                    q = 64'd256;
                o.inside_res = 1'b1;
                o.out_x = rpis_pkg::POS_W'(px - pull(dx, 64'd256 - q));
                o.out_y = rpis_pkg::POS_W'(py - pull(dy, 64'd256 - q));
            end
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_pixels.push_back(shade(item));
                void'(pending_items.pop_front());
            end
            if ((item_valid && item_stall) ||
                (!hold_send && pending_items.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct))
            begin
                item_valid <= 1'b1;
                if (!(item_valid && item_stall))
                    item <= pending_items[0];
            end
            else
                item_valid <= 1'b0;
            res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rpis_pkg::out_item_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (res.out_x !== e.out_x)
                begin $error("out_x exp %h got %h", e.out_x, res.out_x); errors++; end
                if (res.out_y !== e.out_y)
                begin $error("out_y exp %h got %h", e.out_y, res.out_y); errors++; end
                if (res.red_out !== e.red_out)
                begin $error("red_out exp %h got %h", e.red_out, res.red_out); errors++; end
                if (res.green_out !== e.green_out)
                begin $error("green_out exp %h got %h", e.green_out, res.green_out); errors++; end
                if (res.blue_out !== e.blue_out)
                begin $error("blue_out exp %h got %h", e.blue_out, res.blue_out); errors++; end
                if (res.inside_res !== e.inside_res)
                begin $error("inside_res exp %b got %b", e.inside_res, res.inside_res); errors++; end
            end
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpis_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == rpis_pkg::CFG_CENTER_X)
            cen_x = sext(val);
        else if (idx == rpis_pkg::CFG_CENTER_Y)
            cen_y = sext(val);
        else
            rad_q = val[rpis_pkg::RAD_W-1:0];
    endtask

    task automatic set_effect(input logic [rpis_pkg::CFG_W-1:0] cx,
                              input logic [rpis_pkg::CFG_W-1:0] cy,
                              input logic [rpis_pkg::CFG_W-1:0] r);
        write_reg(rpis_pkg::CFG_CENTER_X, cx);
        write_reg(rpis_pkg::CFG_CENTER_Y, cy);
        write_reg(rpis_pkg::CFG_RADIUS, r);
        cfg_we <= 1'b0;
    endtask

    function automatic rpis_pkg::in_item_t make_item(input logic f,
                                                     input logic signed [63:0] x,
                                                     input logic signed [63:0] y);
        rpis_pkg::in_item_t it;
        it.func = f;
        it.pos_x = rpis_pkg::POS_W'(x);
        it.pos_y = rpis_pkg::POS_W'(y);
        it.red_in = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in = 8'($urandom);
        return it;
    endfunction

    task automatic random_batch(input int n);
        int spread;
        logic signed [63:0] ox, oy;
        spread = int'(rad_q) + 64;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                ox = $signed(64'($urandom_range(2 * spread))) - spread;
                oy = $signed(64'($urandom_range(2 * spread))) - spread;
                pending_items.push_back(make_item(1'($urandom), cen_x + ox, cen_y + oy));
            end
            else
                pending_items.push_back(make_item(1'($urandom), $signed($urandom),
                                                  $signed($urandom)));
        end
    endtask

    initial
    begin
        cen_x = 0;
        cen_y = 0;
        rad_q = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rpis_pkg::CFG_CENTER_X;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        res_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero radius: pass-through
        pending_items.push_back(make_item(1'b0, 524287, -524288));
        pending_items.push_back(make_item(1'b1, -524288, 524287));
        drain();

        set_effect(20'd0, 20'd0, 20'd2560);
        pending_items.push_back(make_item(1'b0, 0, 0));
        pending_items.push_back(make_item(1'b1, 0, 0));
        pending_items.push_back(make_item(1'b0, 2559, 0));
        pending_items.push_back(make_item(1'b0, 2560, 0));
        pending_items.push_back(make_item(1'b0, -1000, 1500));
        pending_items.push_back(make_item(1'b1, -2559, 0));
        pending_items.push_back(make_item(1'b1, 2560, 0));
        pending_items.push_back(make_item(1'b1, 1800, -1800));
        pending_items.push_back(make_item(1'b0, -255, -255));
        pending_items.push_back({1'b1, 20'd5, 20'd5, 8'hff, 8'h00, 8'haa});
        pending_items.push_back({1'b1, 20'd5, 20'd5, 8'h00, 8'hff, 8'h55});
        drain();

        set_effect(20'h80000, 20'h7ffff, 20'h7ffff);
        pending_items.push_back(make_item(1'b0, 524287, -524288));
        pending_items.push_back(make_item(1'b1, 524287, -524288));
        pending_items.push_back(make_item(1'b0, -524288, 524287));
        pending_items.push_back(make_item(1'b1, -524288, 524000));
        drain();

        send_idle_pct = 35;
        recv_idle_pct = 47;
        set_effect(rpis_pkg::CFG_W'($urandom), rpis_pkg::CFG_W'($urandom), 20'd1000);
        random_batch(200);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 35;
        set_effect(rpis_pkg::CFG_W'($urandom), rpis_pkg::CFG_W'($urandom),
                   rpis_pkg::CFG_W'($urandom_range(524287)));
        random_batch(100);
        drain();
        set_effect(20'h7ffff, 20'h80000, 20'd4000);
        random_batch(100);
        while (pending_items.size() > 50)
            @(posedge clk);
        hold_send = 1'b1;
        while (item_valid || expected_pixels.size() != 0)
            @(posedge clk);
        hold_send = 1'b0;
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_effect(rpis_pkg::CFG_W'($urandom), rpis_pkg::CFG_W'($urandom), 20'd1);
        random_batch(50);
        drain();
        set_effect(rpis_pkg::CFG_W'($urandom), rpis_pkg::CFG_W'($urandom), 20'd20000);
        random_batch(250);
        drain();

        if (errors == 0)
            $display("radial_pinch_and_invert_shader verification clean");
        else
            $display("radial_pinch_and_invert_shader verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("radial_pinch_and_invert_shader verification failed");
        $finish;
    end
endmodule

### sim.f
rtl/rpis_pkg.sv
rtl/rpis_sqrt_cell.sv
rtl/rpis_div_cell.sv
rtl/radial_pinch_and_invert_shader.sv
dv/tb_radial_pinch_and_invert_shader.sv
